### hw/rtl/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types and constants for the core load assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

    localparam int LOAD_W = 11;   // per-core load and capacity width
    localparam int TASK_W = 12;   // task load width
    localparam int CORE_W = 2;    // core number width on the ports
    localparam int STAT_W = 2;

    localparam logic [LOAD_W-1:0] CAP_RESET = 11'd1024;

    localparam logic MODE_ASSIGN  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] ST_REL_SAT  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;    // item accepted: latch payload, reset accumulators
        logic scan_rd;  // read the load of the scanned core
        logic rel_rd;   // read the load of the release core
        logic commit;   // write the update and register the result
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/core_load_assigner.sv
// ----------------------------------------------------------------------------
// core_load_assigner
// Tracks a fixed-point load per core (1024 = one full core), assigns tasks
// to an idle or the least-loaded core, and releases finished tasks.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  --------  -----------------  ----------------------------------------------
//  request   start / busy       i_mode, i_task_load, i_release_core
//  result    o_done (1 cycle)   o_status, o_chosen_core, o_fallback_used,
//                               o_core_load_after
//  config    i_cfg_we           i_cfg_wdata (core capacity)
//
//  An assign scans the load table one core per memory read, and a release
//  reads only the release core before the commit. The result strobe comes in
//  the cycle after the last busy cycle, and the next item may be accepted in
//  that same cycle.
//  Reset (synchronous, active low) zeroes all core loads and sets the
//  capacity to 1024. The receiver cannot stall; each result shows for
//  exactly one cycle.
//
`default_nettype none

module core_load_assigner #(
    parameter int NUM_CORES = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_mode,
    input  wire logic [cla_pkg::TASK_W-1:0]          i_task_load,
    input  wire logic [cla_pkg::CORE_W-1:0]          i_release_core,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [cla_pkg::LOAD_W-1:0]          i_cfg_wdata,
    // result channel
    output logic                                     o_done,
    output logic [cla_pkg::STAT_W-1:0]               o_status,
    output logic [cla_pkg::CORE_W-1:0]               o_chosen_core,
    output logic                                     o_fallback_used,
    output logic [cla_pkg::LOAD_W-1:0]               o_core_load_after
);

    cla_pkg::t_cmd                 cmd;
    logic [$clog2(NUM_CORES)-1:0]  scan_idx;

    // Sequencer: accept, scan each core or read the release core, then commit the update
    cla_ctrl #(
        .NUM_CORES (NUM_CORES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_mode     (i_mode),
        .o_cmd      (cmd),
        .o_scan_idx (scan_idx),
        .o_busy     (busy)
    );

    // Load table, accumulators and result registers
    cla_dpath #(
        .NUM_CORES (NUM_CORES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_scan_idx        (scan_idx),
        .i_mode            (i_mode),
        .i_task_load       (i_task_load),
        .i_release_core    (i_release_core),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_chosen_core     (o_chosen_core),
        .o_fallback_used   (o_fallback_used),
        .o_core_load_after (o_core_load_after)
    );

endmodule

`default_nettype wire

### hw/rtl/cla_ctrl.sv
// ----------------------------------------------------------------------------
// cla_ctrl
// Sequencer: scans the load table one core per cycle for an assign, or reads the release core, then commits.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_ctrl #(
    parameter int NUM_CORES = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_mode,
    output cla_pkg::t_cmd                       o_cmd,
    output logic [$clog2(NUM_CORES)-1:0]        o_scan_idx,
    output logic                                o_busy
);

    localparam int IW = $clog2(NUM_CORES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_REL    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_idx       = '0;
                    n_state     = (i_mode == cla_pkg::MODE_RELEASE) ? S_REL : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_idx == IW'(NUM_CORES - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_COMMIT;  // last read is evaluated here
            end
            S_REL: begin
                o_cmd.rel_rd = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_scan_idx = r_idx;
    assign o_busy     = (r_state != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/cla_dpath.sv
// ----------------------------------------------------------------------------
// cla_dpath
// Load table, capacity register, scan accumulators and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_dpath #(
    parameter int NUM_CORES = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cla_pkg::t_cmd                       i_cmd,
    input  wire logic [$clog2(NUM_CORES)-1:0]        i_scan_idx,
    input  wire logic                                i_mode,
    input  wire logic [cla_pkg::TASK_W-1:0]          i_task_load,
    input  wire logic [cla_pkg::CORE_W-1:0]          i_release_core,
    input  wire logic                                i_cfg_we,
    input  wire logic [cla_pkg::LOAD_W-1:0]          i_cfg_wdata,
    output logic                                     o_done,
    output logic [cla_pkg::STAT_W-1:0]               o_status,
    output logic [cla_pkg::CORE_W-1:0]               o_chosen_core,
    output logic                                     o_fallback_used,
    output logic [cla_pkg::LOAD_W-1:0]               o_core_load_after
);

    localparam int IW = $clog2(NUM_CORES);
    localparam int LW = cla_pkg::LOAD_W;
    localparam int TW = cla_pkg::TASK_W;

    // Capacity register
    logic [LW-1:0] r_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cla_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // Latched request
    logic                        r_mode;
    logic [TW-1:0]               r_load;
    logic [cla_pkg::CORE_W-1:0]  r_rel;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mode <= i_mode;
            r_load <= i_task_load;
            r_rel  <= i_release_core;
        end
    end

    logic [IW+1:0] rel_ext;
    logic [IW-1:0] rel_idx;
    logic          rel_ok;
    assign rel_ext = {{IW{1'b0}}, r_rel};
    assign rel_idx = rel_ext[IW-1:0];
    assign rel_ok  = (rel_ext < (IW+2)'(NUM_CORES));

    // Load table with per-entry valid bits; an unwritten entry reads as zero
    logic [LW-1:0]        r_mem [NUM_CORES];
    logic [NUM_CORES-1:0] r_valid;
    logic [LW-1:0]        r_rd_data;
    logic                 r_rd_ok;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_scan_vld;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [LW-1:0]        wr_data;
    logic [LW-1:0]        rd_load;

    assign rd_addr = i_cmd.rel_rd ? rel_idx : i_scan_idx;
    assign rd_load = r_rd_ok ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_valid[rd_addr];
        r_rd_idx  <= rd_addr;
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_rd;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Scan accumulators
    logic          r_fits;
    logic          r_found;
    logic [IW-1:0] r_idle_idx;
    logic [LW-1:0] r_min;
    logic [IW-1:0] r_min_idx;
    logic [TW:0]   sum_scan;
    assign sum_scan = {2'b00, rd_load} + {1'b0, r_load};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_fits     <= 1'b0;
            r_found    <= 1'b0;
            r_idle_idx <= '0;
            r_min      <= '1;
            r_min_idx  <= '0;
        end else if (r_scan_vld) begin
            if (sum_scan <= {2'b00, r_cap}) begin
                r_fits <= 1'b1;
            end
            if (!r_found && rd_load == '0) begin
                r_found    <= 1'b1;
                r_idle_idx <= r_rd_idx;
            end
            // strict compare keeps the lowest index on ties
            if (rd_load < r_min) begin
                r_min     <= rd_load;
                r_min_idx <= r_rd_idx;
            end
        end
    end

    // Commit: pick the core, form the update and the result
    logic [IW-1:0]               pick;
    logic [LW-1:0]               base;
    logic [IW+1:0]               pick_ext;
    logic [LW-1:0]               new_load;
    logic [cla_pkg::STAT_W-1:0]  n_status;
    logic [cla_pkg::CORE_W-1:0]  n_chosen;
    logic                        n_fallback;
    logic [LW-1:0]               n_after;

    assign pick     = r_found ? r_idle_idx : r_min_idx;
    assign base     = r_found ? '0 : r_min;
    assign pick_ext = {2'b00, pick};

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = pick;
        wr_data    = '0;
        new_load   = '0;
        n_status   = cla_pkg::ST_REFUSED;
        n_chosen   = '0;
        n_fallback = 1'b0;
        n_after    = '0;
        if (r_mode == cla_pkg::MODE_ASSIGN) begin
            if (r_fits) begin
                new_load   = base + r_load[LW-1:0];
                wr_en      = i_cmd.commit;
                wr_data    = new_load;
                n_status   = cla_pkg::ST_ASSIGNED;
                n_chosen   = pick_ext[cla_pkg::CORE_W-1:0];
                n_fallback = !r_found;
                n_after    = new_load;
            end
        end else begin
            n_status = cla_pkg::ST_RELEASED;
            n_chosen = r_rel;
            wr_addr  = rel_idx;
            if (rel_ok) begin
                if (r_load > {1'b0, rd_load}) begin
                    new_load = '0;
                    n_status = cla_pkg::ST_REL_SAT;
                end else begin
                    new_load = rd_load - r_load[LW-1:0];
                end
                wr_en   = i_cmd.commit;
                wr_data = new_load;
                n_after = new_load;
            end
        end
    end

    // Result registers
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
        end
    end

    logic [cla_pkg::STAT_W-1:0] r_status;
    logic [cla_pkg::CORE_W-1:0] r_chosen;
    logic                       r_fallback;
    logic [LW-1:0]              r_after;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_chosen   <= n_chosen;
            r_fallback <= n_fallback;
            r_after    <= n_after;
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_chosen_core     = r_chosen;
    assign o_fallback_used   = r_fallback;
    assign o_core_load_after = r_after;

endmodule

`default_nettype wire

### hw/rtl/cla_checker.sv
// ----------------------------------------------------------------------------
// cla_checker
// Port-level checks for the core load assigner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_done,
    input wire logic [cla_pkg::STAT_W-1:0]     o_status,
    input wire logic [cla_pkg::CORE_W-1:0]     o_chosen_core,
    input wire logic                           o_fallback_used,
    input wire logic [cla_pkg::LOAD_W-1:0]     o_core_load_after
);

    // an accepted item always occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished item");

    // a refusal leaves every other field at zero
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == cla_pkg::ST_REFUSED) |->
            (o_chosen_core == '0 && !o_fallback_used && o_core_load_after == '0))
        else $error("refused result carries nonzero fields");

    // a release never reports the fallback pick
    a_release_no_fb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == cla_pkg::ST_RELEASED ||
                    o_status == cla_pkg::ST_REL_SAT)) |-> !o_fallback_used)
        else $error("release reported fallback");

    // a saturated release leaves the core empty
    a_sat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == cla_pkg::ST_REL_SAT) |-> (o_core_load_after == '0))
        else $error("saturated release left a nonzero load");

endmodule

bind core_load_assigner cla_checker u_cla_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_chosen_core     (o_chosen_core),
    .o_fallback_used   (o_fallback_used),
    .o_core_load_after (o_core_load_after)
);

`default_nettype wire

### bench/core_load_assigner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_load_assigner_tb
// Drives assign and release requests into the core load assigner, keeps a
// private copy of the per-core load table and the capacity, and checks every
// result strobe field by field against the expected outcome, in order.
// ----------------------------------------------------------------------------

module core_load_assigner_tb;

    localparam int NUM_CORES = 4;
    localparam int SETTLE    = NUM_CORES + 8;  // cycles to let the block go quiet
    localparam int WD_LIMIT  = 1000;           // cycles with no traffic at all

    typedef struct packed {
        logic                       mode;
        logic [cla_pkg::TASK_W-1:0] load;
        logic [cla_pkg::CORE_W-1:0] core;
    } t_req;

    typedef struct packed {
        logic [cla_pkg::STAT_W-1:0] status;
        logic [cla_pkg::CORE_W-1:0] core;
        logic                       fallback;
        logic [cla_pkg::LOAD_W-1:0] after;
    } t_res;

    // DUT connections; every input starts at a known value
    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       start          = 1'b0;
    logic                       i_mode         = cla_pkg::MODE_ASSIGN;
    logic [cla_pkg::TASK_W-1:0] i_task_load    = '0;
    logic [cla_pkg::CORE_W-1:0] i_release_core = '0;
    logic                       i_cfg_we       = 1'b0;
    logic [cla_pkg::LOAD_W-1:0] i_cfg_wdata    = '0;
    logic                       busy;
    logic                       o_done;
    logic [cla_pkg::STAT_W-1:0] o_status;
    logic [cla_pkg::CORE_W-1:0] o_chosen_core;
    logic                       o_fallback_used;
    logic [cla_pkg::LOAD_W-1:0] o_core_load_after;

    // Requests waiting to be presented, and outcomes waiting for their strobe
    t_req pending_reqs[$];
    t_res expected_res[$];

    // Shadow copy of the block's state
    logic [cla_pkg::LOAD_W-1:0] load_tab [NUM_CORES];
    logic [cla_pkg::LOAD_W-1:0] cap_model = cla_pkg::CAP_RESET;

    logic req_taken   = 1'b0;  // an item was accepted at the last rising edge
    int   idle_left   = 0;     // idle cycles still owed before the next item
    logic no_idle     = 1'b0;  // burst mode: present items back to back
    int   idle_cycles = 0;
    int   fail_cnt    = 0;

    core_load_assigner #(
        .NUM_CORES(NUM_CORES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_task_load      (i_task_load),
        .i_release_core   (i_release_core),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_chosen_core    (o_chosen_core),
        .o_fallback_used  (o_fallback_used),
        .o_core_load_after(o_core_load_after)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_CORES; i++) load_tab[i] = '0;
    end

    // ------------------------------------------------------------------------
    // Outcome of one accepted item; advances the shadow load table.
    // An assign that fits on any core goes to the lowest idle core, else to the
    // least-loaded core (lowest index on a tie). A release saturates at zero.
    // ------------------------------------------------------------------------
    function automatic t_res apply_request(input t_req rq);
        t_res r;
        logic fits;
        int   pick;
        r = '0;
        if (rq.mode == cla_pkg::MODE_ASSIGN) begin
            fits = 1'b0;
            for (int i = 0; i < NUM_CORES; i++) begin
                if (int'(load_tab[i]) + int'(rq.load) <= int'(cap_model)) fits = 1'b1;
            end
            if (!fits) begin
                // refused: nothing changes and the other fields stay zero
                r.status = cla_pkg::ST_REFUSED;
            end else begin
                pick = -1;
                for (int i = 0; i < NUM_CORES; i++) begin
                    if (pick < 0 && load_tab[i] == '0) pick = i;
                end
                if (pick < 0) begin
                    // no idle core: fall back to the least-loaded one
                    pick = 0;
                    for (int i = 1; i < NUM_CORES; i++) begin
                        if (load_tab[i] < load_tab[pick]) pick = i;
                    end
                    r.fallback = 1'b1;
                end
                // the chosen core always fits, so the sum never wraps
                load_tab[pick] = load_tab[pick] + rq.load[cla_pkg::LOAD_W-1:0];
                r.status = cla_pkg::ST_ASSIGNED;
                r.core   = cla_pkg::CORE_W'(pick);
                r.after  = load_tab[pick];
            end
        end else begin
            r.status = cla_pkg::ST_RELEASED;
            r.core   = rq.core;
            // a core number beyond the table leaves every load as it is
            if (int'(rq.core) < NUM_CORES) begin
                if (rq.load > cla_pkg::TASK_W'(load_tab[rq.core])) begin
                    load_tab[rq.core] = '0;
                    r.status = cla_pkg::ST_REL_SAT;
                end else begin
                    load_tab[rq.core] = load_tab[rq.core] - rq.load[cla_pkg::LOAD_W-1:0];
                end
                r.after = load_tab[rq.core];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold an item until it is
    // taken, then insert a random number of idle cycles before the next one.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req nxt;
        int   r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (idle_left != 0) begin
                // idle: drop start and scramble the payload
                start          <= 1'b0;
                idle_left      <= idle_left - 1;
                i_mode         <= 1'($urandom);
                i_task_load    <= cla_pkg::TASK_W'($urandom);
                i_release_core <= cla_pkg::CORE_W'($urandom);
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                start          <= 1'b1;
                i_mode         <= nxt.mode;
                i_task_load    <= nxt.load;
                i_release_core <= nxt.core;
                r = $urandom_range(0, 99);
                if (no_idle || r < 60) idle_left <= 0;
                else if (r < 90)       idle_left <= $urandom_range(1, 3);
                else                   idle_left <= $urandom_range(4, 30);
                // switch in and out of back-to-back stretches now and then
                if (no_idle ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 79) == 0))
                    no_idle <= !no_idle;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge. Check a strobed result against the
    // oldest expectation first, then track config writes and accepted items.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        t_req rq;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (o_done) begin
                if (expected_res.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result with nothing expected, got status %0d core %0d",
                             $time, o_status, o_chosen_core);
                end else begin
                    want = expected_res.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("chosen_core", want.core, o_chosen_core);
                    check_field("fallback_used", want.fallback, o_fallback_used);
                    check_field("core_load_after", want.after, o_core_load_after);
                end
            end
            if (i_cfg_we) cap_model = i_cfg_wdata;
            if (start && !busy) begin
                rq.mode = i_mode;
                rq.load = i_task_load;
                rq.core = i_release_core;
                expected_res.insert(expected_res.size(), apply_request(rq));
            end
            req_taken <= start && !busy;
            // watchdog: any accepted item, result or write counts as progress
            if ((start && !busy) || o_done || i_cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WD_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_req(input logic mode, input int load, input int core);
        t_req rq;
        rq.mode = mode;
        rq.load = cla_pkg::TASK_W'(load);
        rq.core = cla_pkg::CORE_W'(core);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // Hold until every queued item is taken and every result is back,
    // then give the block time to go fully quiet.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_res.size() != 0 || start)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_capacity(input int cap);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cla_pkg::LOAD_W'(cap);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random traffic shaped around the current capacity: mostly loads small
    // enough that several tasks share a core, so the table fills up, falls
    // back to the least-loaded core, refuses, and drains through releases.
    task automatic gen_traffic(input int n, input int cap, input int assign_pct);
        int   span;
        int   r;
        int   ld;
        logic m;
        span = (cap < 16) ? 16 : cap;
        repeat (n) begin
            m = ($urandom_range(0, 99) < assign_pct) ? cla_pkg::MODE_ASSIGN
                                                     : cla_pkg::MODE_RELEASE;
            r = $urandom_range(0, 99);
            if (r < 6)       ld = $urandom_range(0, 4095);
            else if (r < 10) ld = 0;
            else if (r < 14) ld = cap;
            else if (r < 30) ld = $urandom_range(1, 8);
            else             ld = $urandom_range(1, span / 3 + 1);
            push_req(m, ld, $urandom_range(0, NUM_CORES - 1));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at the reset capacity of one full core
        push_req(cla_pkg::MODE_ASSIGN, 0, 0);       // zero load: core 0 stays idle
        push_req(cla_pkg::MODE_ASSIGN, 1024, 0);    // exactly at capacity on core 0
        push_req(cla_pkg::MODE_ASSIGN, 1025, 0);    // above capacity: refused
        push_req(cla_pkg::MODE_ASSIGN, 4095, 3);    // largest task load: refused
        push_req(cla_pkg::MODE_ASSIGN, 512, 0);     // core 1
        push_req(cla_pkg::MODE_ASSIGN, 256, 0);     // core 2
        push_req(cla_pkg::MODE_ASSIGN, 100, 0);     // core 3, no idle core left now
        push_req(cla_pkg::MODE_ASSIGN, 50, 0);      // fallback to core 3
        push_req(cla_pkg::MODE_ASSIGN, 106, 0);     // fallback, core 3 ties core 2 at 256
        push_req(cla_pkg::MODE_ASSIGN, 1, 0);       // tie goes to the lower index, core 2
        push_req(cla_pkg::MODE_ASSIGN, 1000, 0);    // nothing fits: refused
        push_req(cla_pkg::MODE_RELEASE, 1024, 0);   // exact release, core 0 back to zero
        push_req(cla_pkg::MODE_RELEASE, 5, 0);      // release below zero: saturate
        push_req(cla_pkg::MODE_RELEASE, 4095, 1);   // largest release: saturate
        push_req(cla_pkg::MODE_RELEASE, 0, 3);      // zero release leaves the load
        push_req(cla_pkg::MODE_RELEASE, 257, 2);    // exact release on core 2
        push_req(cla_pkg::MODE_ASSIGN, 768, 3);     // lowest idle core again
        push_req(cla_pkg::MODE_RELEASE, 2047, 3);   // saturate on the top core number

        // Random phases across capacity settings, extremes included
        set_capacity(2047);
        gen_traffic(250, 2047, 70);
        set_capacity(0);
        gen_traffic(80, 0, 50);
        set_capacity(1);
        gen_traffic(80, 1, 60);
        set_capacity(1024);
        gen_traffic(300, 1024, 65);
        set_capacity($urandom_range(2, 2046));
        gen_traffic(250, int'(cap_model), 60);
        set_capacity(2047);
        gen_traffic(200, 2047, 40);
        set_capacity($urandom_range(2, 2046));
        gen_traffic(250, int'(cap_model), 70);
        set_capacity(1024);
        gen_traffic(200, 1024, 55);

        wait_idle();
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/cla_pkg.sv
hw/rtl/cla_ctrl.sv
hw/rtl/cla_dpath.sv
hw/rtl/core_load_assigner.sv
hw/rtl/cla_checker.sv
bench/core_load_assigner_tb.sv
